// ===== rtl/ptrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrm_pkg: shared types, codes and trig tables for pose_to_rotation_matrix
// Mode and result kind codes, the item record handed to the serializer, the
// rounding helper, and sine/cosine tables built at elaboration.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TRANS = 2'd0;
  localparam mode_t MODE_QUAT  = 2'd1;
  localparam mode_t MODE_EULER = 2'd2;
  localparam mode_t MODE_BOTH  = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TRANS = 2'd0;
  localparam kind_t KIND_ROW0  = 2'd1;
  localparam kind_t KIND_ROW1  = 2'd2;
  localparam kind_t KIND_ROW2  = 2'd3;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    mode_t                  mode;
    logic [5:0]             sensor;
    logic signed [31:0]     t0;
    logic signed [31:0]     t1;
    logic signed [31:0]     t2;
    logic [2:0][2:0][15:0]  rows;
  } item_t;

  // Angles in 1/64 degree
  localparam int UNITS_QUARTER = 5760;
  localparam int UNITS_FULL    = 23040;

  localparam logic [63:0] Q62_ONE  = 64'h4000000000000000;
  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
  localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd11520;

  // Table widths, all Q36
  localparam int SC_W = 37;
  localparam int SF_W = 31;
  localparam int DF_W = 24;

  typedef logic [89:0][SC_W-1:0] deg_tab_t;
  typedef logic [63:0][SF_W-1:0] fine_s_t;
  typedef logic [63:0][DF_W-1:0] fine_d_t;

  // Round half up by 2^sh, saturate to Q2.14
  function automatic q14_t q14_from(input logic signed [47:0] v, input int unsigned sh);
    logic signed [47:0] r;
    r = (v + (48'sd1 <<< (sh - 1))) >>> sh;
    if (r > 48'sd32767) begin
      return 16'sh7fff;
    end else if (r < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring shift-subtract quotient for the elaboration-time series
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series in Q62, evaluated at elaboration only
  function automatic logic [63:0] taylor(input int unsigned u, input bit use_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    x = 64'(u) * STEP_Q62;
    x2 = mul_q62(x, x);
    term = use_cos ? Q62_ONE : x;
    sum = term;
    for (int k = 1; k <= 13; k++) begin
      d = use_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = div_u64(mul_q62(term, x2), d);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [37:0] to_q36(input logic [63:0] v);
    return 38'((v + 64'd33554432) >> 26);
  endfunction

  function automatic deg_tab_t make_deg_tab(input bit use_cos);
    deg_tab_t t;
    for (int d = 0; d < 90; d++) begin
      t[d] = SC_W'(to_q36(taylor(d * 64, use_cos)));
    end
    return t;
  endfunction

  function automatic fine_s_t make_sin_fine();
    fine_s_t t;
    for (int j = 0; j < 64; j++) begin
      t[j] = SF_W'(to_q36(taylor(j, 1'b0)));
    end
    return t;
  endfunction

  // One minus cosine of the fine step
  function automatic fine_d_t make_dcos_fine();
    fine_d_t t;
    for (int j = 0; j < 64; j++) begin
      t[j] = DF_W'(to_q36(Q62_ONE - taylor(j, 1'b1)));
    end
    return t;
  endfunction

  localparam deg_tab_t SIN_DEG   = make_deg_tab(1'b0);
  localparam deg_tab_t COS_DEG   = make_deg_tab(1'b1);
  localparam fine_s_t  SIN_FINE  = make_sin_fine();
  localparam fine_d_t  DCOS_FINE = make_dcos_fine();

endpackage

// ===== rtl/pose_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// pose_to_rotation_matrix: tracker pose to scaled translation and rotation rows
// An item is taken when start is high and busy is low. Items stream through an
// eight-stage pipeline and then a serializer that emits one result per cycle on
// the strobe: one result for mode 0, three for mode 1, four for modes 2 and 3.
// The serializer sets the rate: it holds an item until its last result and the
// whole pipeline stalls meanwhile, so items are taken back to back only while
// the serializer is empty or on its last result. Results cannot be held off;
// busy rises only while the serializer still has results of an earlier item.
// ----------------------------------------------------------------------------
module pose_to_rotation_matrix
  import ptrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mode_t              mode,
  input  logic [5:0]         sensor_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] rot_0,
  input  logic signed [15:0] rot_1,
  input  logic signed [15:0] rot_2,
  input  logic signed [15:0] rot_3,
  input  logic               scale_we,
  input  logic [15:0]        scale_data,
  output logic               strobe,
  output logic [5:0]         sensor_out,
  output kind_t              kind,
  output logic signed [31:0] value_0,
  output logic signed [31:0] value_1,
  output logic signed [31:0] value_2,
  output logic               last
);

  logic [15:0] scale;
  logic [7:0]  v;
  logic        adv;
  logic        accept;

  // Stage 1
  mode_t              mode1;
  logic [5:0]         sensor1;
  logic signed [31:0] px1, py1, pz1;
  logic signed [15:0] w1, x1, y1, z1;

  // Stage 2
  mode_t              mode2;
  logic [5:0]         sensor2;
  logic signed [47:0] tx2, ty2, tz2;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;

  // Stages 3 to 8
  item_t pipe [6];
  item_t item3;
  item_t item8;

  logic signed [47:0] tx_c, ty_c, tz_c;
  logic signed [31:0] ww_c, xx_c, yy_c, zz_c, xy_c, wz_c, xz_c, wy_c, yz_c, wx_c;

  q14_t sa, ca, se, ce, sr, cr;
  logic [2:0][2:0][15:0] euler_rows;

  assign accept = start && !busy;
  assign busy = !adv;

  assign tx_c = px1 * $signed({1'b0, scale});
  assign ty_c = py1 * $signed({1'b0, scale});
  assign tz_c = pz1 * $signed({1'b0, scale});
  assign ww_c = w1 * w1;
  assign xx_c = x1 * x1;
  assign yy_c = y1 * y1;
  assign zz_c = z1 * z1;
  assign xy_c = x1 * y1;
  assign wz_c = w1 * z1;
  assign xz_c = x1 * z1;
  assign wy_c = w1 * y1;
  assign yz_c = y1 * z1;
  assign wx_c = w1 * x1;

  function automatic logic signed [31:0] trans(input logic signed [47:0] p);
    logic signed [47:0] r;
    r = (p + 48'sd2048) >>> 12;
    if (r > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -48'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return r[31:0];
    end
  endfunction

  function automatic logic signed [47:0] x2(input logic signed [31:0] a);
    return 48'(a) <<< 1;
  endfunction

  always_comb begin
    item3.mode = mode2;
    item3.sensor = sensor2;
    item3.t0 = trans(tx2);
    item3.t1 = trans(ty2);
    item3.t2 = trans(tz2);
    item3.rows[0][0] = q14_from(x2(xy) - x2(wz), 14);
    item3.rows[0][1] = q14_from(x2(xz) + x2(wy), 14);
    item3.rows[0][2] = q14_from(48'(ww) + 48'(xx) - 48'(yy) - 48'(zz), 14);
    item3.rows[1][0] = q14_from(48'(ww) - 48'(xx) + 48'(yy) - 48'(zz), 14);
    item3.rows[1][1] = q14_from(x2(yz) - x2(wx), 14);
    item3.rows[1][2] = q14_from(x2(xy) + x2(wz), 14);
    item3.rows[2][0] = q14_from(x2(yz) + x2(wx), 14);
    item3.rows[2][1] = q14_from(48'(ww) - 48'(xx) - 48'(yy) + 48'(zz), 14);
    item3.rows[2][2] = q14_from(x2(xz) - x2(wy), 14);
  end

  // For mode 2 only, Euler rows replace the quaternion rows at the last stage
  always_comb begin
    item8 = pipe[5];
    if (pipe[5].mode == MODE_EULER) begin
      item8.rows = euler_rows;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      scale <= 16'd4096;
    end else begin
      if (scale_we) begin
        scale <= scale_data;
      end
      if (adv) begin
        v <= {v[6:0], accept};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= mode;
      sensor1 <= sensor_index;
      px1 <= pos_x;
      py1 <= pos_y;
      pz1 <= pos_z;
      w1 <= rot_0;
      x1 <= rot_1;
      y1 <= rot_2;
      z1 <= rot_3;

      mode2 <= mode1;
      sensor2 <= sensor1;
      tx2 <= tx_c;
      ty2 <= ty_c;
      tz2 <= tz_c;
      ww <= ww_c;
      xx <= xx_c;
      yy <= yy_c;
      zz <= zz_c;
      xy <= xy_c;
      wz <= wz_c;
      xz <= xz_c;
      wy <= wy_c;
      yz <= yz_c;
      wx <= wx_c;

      pipe[0] <= item3;
      for (int i = 1; i < 6; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  ptrm_trig u_trig_az (.clk(clk), .adv(adv), .angle(w1), .sin_val(sa), .cos_val(ca));
  ptrm_trig u_trig_el (.clk(clk), .adv(adv), .angle(x1), .sin_val(se), .cos_val(ce));
  ptrm_trig u_trig_ro (.clk(clk), .adv(adv), .angle(y1), .sin_val(sr), .cos_val(cr));

  ptrm_euler u_euler (
    .clk  (clk),
    .adv  (adv),
    .sa   (sa),
    .ca   (ca),
    .se   (se),
    .ce   (ce),
    .sr   (sr),
    .cr   (cr),
    .rows (euler_rows)
  );

  ptrm_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[7]),
    .item       (item8),
    .take       (adv),
    .strobe     (strobe),
    .sensor_out (sensor_out),
    .kind       (kind),
    .value_0    (value_0),
    .value_1    (value_1),
    .value_2    (value_2),
    .last       (last)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> v[0])
    else $error("accepted item missing from first stage");

  a_results_continue: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside an item's results");

  a_kind_steps: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (kind == $past(kind) + 2'd1))
    else $error("result kinds out of order");

  a_row2_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_ROW2) |-> last)
    else $error("last row not marked last");

endmodule

// ===== rtl/ptrm_trig.sv =====
// ----------------------------------------------------------------------------
// ptrm_trig: sine and cosine of one angle in 1/64 degree, Q2.14
// Four stages: quadrant reduction, table lookup, fine-step products, combine
// and round.
// ----------------------------------------------------------------------------
module ptrm_trig
  import ptrm_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic signed [15:0] angle,
  output q14_t              sin_val,
  output q14_t              cos_val
);

  logic signed [17:0] a18;
  logic signed [17:0] m18;
  logic [14:0]        m;
  logic [1:0]         q_c;
  logic [12:0]        r_c;

  logic [1:0]      q2, q3, q4;
  logic [12:0]     r2;
  logic [SC_W-1:0] sc3, cc3, sc4, cc4;
  logic [SF_W-1:0] sf3;
  logic [DF_W-1:0] df3;
  logic [31:0]     p_cs, p_ss;
  logic [24:0]     p_sd, p_cd;

  logic [63:0] m_cs, m_ss;
  logic [56:0] m_sd, m_cd;
  logic [38:0] sin_sum, cos_sum;
  logic [15:0] sin_mag, cos_mag;
  logic        sin_neg, cos_neg;

  // Reduce modulo a full turn and split into quadrant and remainder
  always_comb begin
    a18 = 18'(angle);
    if (a18 < 0) begin
      m18 = a18 + 18'(UNITS_FULL);
      if (m18 < 0) begin
        m18 = m18 + 18'(UNITS_FULL);
      end
    end else if (a18 >= 18'(UNITS_FULL)) begin
      m18 = a18 - 18'(UNITS_FULL);
    end else begin
      m18 = a18;
    end
    m = m18[14:0];
    priority if (m >= 15'(3 * UNITS_QUARTER)) begin
      q_c = 2'd3;
      r_c = 13'(m - 15'(3 * UNITS_QUARTER));
    end else if (m >= 15'(2 * UNITS_QUARTER)) begin
      q_c = 2'd2;
      r_c = 13'(m - 15'(2 * UNITS_QUARTER));
    end else if (m >= 15'(UNITS_QUARTER)) begin
      q_c = 2'd1;
      r_c = 13'(m - 15'(UNITS_QUARTER));
    end else begin
      q_c = 2'd0;
      r_c = m[12:0];
    end
  end

  assign m_cs = 64'(cc3[SC_W-1:4]) * 64'(sf3);
  assign m_ss = 64'(sc3[SC_W-1:4]) * 64'(sf3);
  assign m_sd = 57'(sc3[SC_W-1:4]) * 57'(df3);
  assign m_cd = 57'(cc3[SC_W-1:4]) * 57'(df3);

  // sin(A+B) = sA - sA*(1-cB) + cA*sB, cos likewise, then round to Q14
  always_comb begin
    sin_sum = 39'(sc4) + 39'(p_cs) - 39'(p_sd) + 39'(1 << 21);
    cos_sum = 39'(cc4) - 39'(p_cd) - 39'(p_ss) + 39'(1 << 21);
    sin_mag = q4[0] ? cos_sum[37:22] : sin_sum[37:22];
    cos_mag = q4[0] ? sin_sum[37:22] : cos_sum[37:22];
    sin_neg = q4[1];
    cos_neg = q4[0] ^ q4[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2 <= q_c;
      r2 <= r_c;
      q3 <= q2;
      sc3 <= SIN_DEG[r2[12:6]];
      cc3 <= COS_DEG[r2[12:6]];
      sf3 <= SIN_FINE[r2[5:0]];
      df3 <= DCOS_FINE[r2[5:0]];
      q4 <= q3;
      sc4 <= sc3;
      cc4 <= cc3;
      p_cs <= m_cs[63:32];
      p_ss <= m_ss[63:32];
      p_sd <= m_sd[56:32];
      p_cd <= m_cd[56:32];
      sin_val <= sin_neg ? -$signed(sin_mag) : $signed(sin_mag);
      cos_val <= cos_neg ? -$signed(cos_mag) : $signed(cos_mag);
    end
  end

endmodule

// ===== rtl/ptrm_euler.sv =====
// ----------------------------------------------------------------------------
// ptrm_euler: rotation rows from azimuth, elevation and roll sines/cosines
// Three stages: pair products, triple products, sum and round to Q2.14.
// ----------------------------------------------------------------------------
module ptrm_euler
  import ptrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  adv,
  input  q14_t                  sa,
  input  q14_t                  ca,
  input  q14_t                  se,
  input  q14_t                  ce,
  input  q14_t                  sr,
  input  q14_t                  cr,
  output logic [2:0][2:0][15:0] rows
);

  logic signed [29:0] sa_cr, sa_sr, ca_ce, ca_cr, ca_sr, sa_ce, ce_sr, ce_cr, ca_se, sa_se;
  logic signed [29:0] sa_cr7, sa_sr7, ca_ce7, ca_cr7, ca_sr7, sa_ce7, ce_sr7, ce_cr7;
  q14_t sr6, cr6, se6, se7;
  logic signed [43:0] cse_sr, cse_cr, sse_sr, sse_cr;
  logic signed [31:0] p_sa_cr, p_sa_sr, p_ca_ce, p_ca_cr, p_ca_sr, p_sa_ce;
  logic signed [31:0] p_ce_sr, p_ce_cr, p_ca_se, p_sa_se;
  logic signed [45:0] t_cse_sr, t_cse_cr, t_sse_sr, t_sse_cr;

  assign p_sa_cr = sa * cr;
  assign p_sa_sr = sa * sr;
  assign p_ca_ce = ca * ce;
  assign p_ca_cr = ca * cr;
  assign p_ca_sr = ca * sr;
  assign p_sa_ce = sa * ce;
  assign p_ce_sr = ce * sr;
  assign p_ce_cr = ce * cr;
  assign p_ca_se = ca * se;
  assign p_sa_se = sa * se;

  assign t_cse_sr = ca_se * sr6;
  assign t_cse_cr = ca_se * cr6;
  assign t_sse_sr = sa_se * sr6;
  assign t_sse_cr = sa_se * cr6;

  function automatic logic signed [47:0] up14(input logic signed [29:0] v);
    return 48'(v) <<< 14;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_cr <= p_sa_cr[29:0];
      sa_sr <= p_sa_sr[29:0];
      ca_ce <= p_ca_ce[29:0];
      ca_cr <= p_ca_cr[29:0];
      ca_sr <= p_ca_sr[29:0];
      sa_ce <= p_sa_ce[29:0];
      ce_sr <= p_ce_sr[29:0];
      ce_cr <= p_ce_cr[29:0];
      ca_se <= p_ca_se[29:0];
      sa_se <= p_sa_se[29:0];
      sr6 <= sr;
      cr6 <= cr;
      se6 <= se;

      cse_sr <= t_cse_sr[43:0];
      cse_cr <= t_cse_cr[43:0];
      sse_sr <= t_sse_sr[43:0];
      sse_cr <= t_sse_cr[43:0];
      sa_cr7 <= sa_cr;
      sa_sr7 <= sa_sr;
      ca_ce7 <= ca_ce;
      ca_cr7 <= ca_cr;
      ca_sr7 <= ca_sr;
      sa_ce7 <= sa_ce;
      ce_sr7 <= ce_sr;
      ce_cr7 <= ce_cr;
      se7 <= se6;

      rows[0][0] <= q14_from(up14(sa_cr7) + 48'(cse_sr), 28);
      rows[0][1] <= q14_from(up14(sa_sr7) - 48'(cse_cr), 28);
      rows[0][2] <= q14_from(up14(ca_ce7), 28);
      rows[1][0] <= q14_from(up14(ca_cr7) - 48'(sse_sr), 28);
      rows[1][1] <= q14_from(up14(ca_sr7) + 48'(sse_cr), 28);
      rows[1][2] <= q14_from(-up14(sa_ce7), 28);
      rows[2][0] <= q14_from(-up14(ce_sr7), 28);
      rows[2][1] <= q14_from(up14(ce_cr7), 28);
      rows[2][2] <= se7;
    end
  end

endmodule

// ===== rtl/ptrm_out.sv =====
// ----------------------------------------------------------------------------
// ptrm_out: result serializer
// Holds one finished item and emits its translation, its rows or both, one
// result per cycle, from registered outputs.
// ----------------------------------------------------------------------------
module ptrm_out
  import ptrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              item,
  output logic               take,
  output logic               strobe,
  output logic [5:0]         sensor_out,
  output kind_t              kind,
  output logic signed [31:0] value_0,
  output logic signed [31:0] value_1,
  output logic signed [31:0] value_2,
  output logic               last
);

  logic        hv;
  item_t       h;
  logic [1:0]  cnt;
  kind_t       cur_kind;
  logic        cur_last;
  logic [31:0] v0_c, v1_c, v2_c;

  function automatic logic [31:0] ext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  always_comb begin
    cur_kind = ((h.mode == MODE_QUAT) ? KIND_ROW0 : KIND_TRANS) + cnt;
    cur_last = (h.mode == MODE_TRANS) || (cur_kind == KIND_ROW2);
    take = !hv || cur_last;
    unique case (cur_kind)
      KIND_TRANS: begin
        v0_c = h.t0;
        v1_c = h.t1;
        v2_c = h.t2;
      end
      KIND_ROW0: begin
        v0_c = ext(h.rows[0][0]);
        v1_c = ext(h.rows[0][1]);
        v2_c = ext(h.rows[0][2]);
      end
      KIND_ROW1: begin
        v0_c = ext(h.rows[1][0]);
        v1_c = ext(h.rows[1][1]);
        v2_c = ext(h.rows[1][2]);
      end
      default: begin
        v0_c = ext(h.rows[2][0]);
        v1_c = ext(h.rows[2][1]);
        v2_c = ext(h.rows[2][2]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= hv;
      if (take) begin
        hv <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h <= item;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'd1;
    end
    sensor_out <= h.sensor;
    kind <= cur_kind;
    value_0 <= v0_c;
    value_1 <= v1_c;
    value_2 <= v2_c;
    last <= cur_last;
  end

endmodule

// ===== test/pose_to_rotation_matrix_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pose_to_rotation_matrix_tb: self-checking bench for the pose converter
// Sends pose items in every mode and checks each emitted translation and
// rotation row against a fixed-point predictor, with random sender gaps and
// several scale settings.
// ----------------------------------------------------------------------------
module pose_to_rotation_matrix_tb
  import ptrm_pkg::*;
();

  localparam longint Q14_ONE = 16384;

  typedef struct {
    logic [5:0]         sensor;
    kind_t              kind;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               last;
  } pose_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mode_t mode = MODE_TRANS;
  logic [5:0] sensor_index = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] rot_0 = '0, rot_1 = '0, rot_2 = '0, rot_3 = '0;
  logic scale_we = 1'b0;
  logic [15:0] scale_data = '0;
  logic strobe;
  logic [5:0] sensor_out;
  kind_t kind;
  logic signed [31:0] value_0, value_1, value_2;
  logic last;

  pose_result_t pending_results[$];
  logic [15:0] scale_reg = 16'd4096;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int mode_count[4] = '{0, 0, 0, 0};
  bit burst = 1'b0;

  pose_to_rotation_matrix uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .sensor_index(sensor_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .rot_0(rot_0), .rot_1(rot_1), .rot_2(rot_2), .rot_3(rot_3),
    .scale_we(scale_we), .scale_data(scale_data), .strobe(strobe),
    .sensor_out(sensor_out), .kind(kind), .value_0(value_0), .value_1(value_1),
    .value_2(value_2), .last(last)
  );

  always #10 clk = ~clk;

  // Round half up by 2^sh
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint to_q14(longint v, int sh);
    longint r;
    r = round_shift(v, sh);
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Q14 magnitude of sine over one quadrant, r in 1/64 degree
  function automatic longint quadrant_sine(int r);
    bit use_cos;
    int t;
    logic [63:0] x, x2, term, sum, d;
    use_cos = r > UNITS_QUARTER / 2;
    t = use_cos ? UNITS_QUARTER - r : r;
    x = 64'(t) * STEP_Q62;
    x2 = q62_product(x, x);
    term = use_cos ? Q62_ONE : x;
    sum = term;
    for (int k = 1; k <= 11; k++) begin
      d = use_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = q62_product(term, x2) / d;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return longint'((sum + (64'd1 << 47)) >> 48);
  endfunction

  function automatic longint angle_sine(int a);
    int m, q, r;
    longint mag;
    m = ((a % UNITS_FULL) + UNITS_FULL) % UNITS_FULL;
    q = m / UNITS_QUARTER;
    r = m % UNITS_QUARTER;
    mag = (q % 2 == 1) ? quadrant_sine(UNITS_QUARTER - r) : quadrant_sine(r);
    return q >= 2 ? -mag : mag;
  endfunction

  function automatic longint scale_coord(logic signed [31:0] p);
    longint r;
    r = round_shift(longint'(p) * longint'({16'd0, scale_reg}), 12);
    if (r > 64'sd2147483647) return 64'sd2147483647;
    if (r < -64'sd2147483648) return -64'sd2147483648;
    return r;
  endfunction

  task automatic predict_pose(mode_t m, logic [5:0] s, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              logic signed [15:0] a0, logic signed [15:0] a1,
                              logic signed [15:0] a2, logic signed [15:0] a3);
    longint row[3][3];
    longint sa, ca, se, ce, sr, cr, w, x, y, z, ww, xx, yy, zz;
    pose_result_t res;
    res.sensor = s;
    if (m != MODE_QUAT) begin
      res.kind = KIND_TRANS;
      res.v0 = 32'(scale_coord(px));
      res.v1 = 32'(scale_coord(py));
      res.v2 = 32'(scale_coord(pz));
      res.last = (m == MODE_TRANS);
      pending_results.push_back(res);
    end
    if (m == MODE_TRANS) return;
    if (m == MODE_EULER) begin
      sa = angle_sine(a0); ca = angle_sine(int'(a0) + UNITS_QUARTER);
      se = angle_sine(a1); ce = angle_sine(int'(a1) + UNITS_QUARTER);
      sr = angle_sine(a2); cr = angle_sine(int'(a2) + UNITS_QUARTER);
      row[0][0] = to_q14(sa * cr * Q14_ONE + ca * se * sr, 28);
      row[0][1] = to_q14(sa * sr * Q14_ONE - ca * se * cr, 28);
      row[0][2] = to_q14(ca * ce * Q14_ONE, 28);
      row[1][0] = to_q14(ca * cr * Q14_ONE - sa * se * sr, 28);
      row[1][1] = to_q14(ca * sr * Q14_ONE + sa * se * cr, 28);
      row[1][2] = to_q14(-sa * ce * Q14_ONE, 28);
      row[2][0] = to_q14(-ce * sr * Q14_ONE, 28);
      row[2][1] = to_q14(ce * cr * Q14_ONE, 28);
      row[2][2] = to_q14(se * Q14_ONE * Q14_ONE, 28);
    end else begin
      w = a0; x = a1; y = a2; z = a3;
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      row[0][0] = to_q14(2 * (x * y - w * z), 14);
      row[0][1] = to_q14(2 * (x * z + w * y), 14);
      row[0][2] = to_q14(ww + xx - yy - zz, 14);
      row[1][0] = to_q14(ww - xx + yy - zz, 14);
      row[1][1] = to_q14(2 * (y * z - w * x), 14);
      row[1][2] = to_q14(2 * (x * y + w * z), 14);
      row[2][0] = to_q14(2 * (y * z + w * x), 14);
      row[2][1] = to_q14(ww - xx - yy + zz, 14);
      row[2][2] = to_q14(2 * (x * z - w * y), 14);
    end
    for (int i = 0; i < 3; i++) begin
      res.kind = kind_t'(i + 1);
      res.v0 = 32'(row[i][0]);
      res.v1 = 32'(row[i][1]);
      res.v2 = 32'(row[i][2]);
      res.last = (i == 2);
      pending_results.push_back(res);
    end
  endtask

  // Hold start between back-to-back items; drop it only when a gap follows
  task automatic sender_gap();
    int n;
    n = burst ? 0 : $urandom_range(18);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pose(mode_t m, logic [5:0] s, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz,
                           logic signed [15:0] a0, logic signed [15:0] a1,
                           logic signed [15:0] a2, logic signed [15:0] a3);
    sender_gap();
    start <= 1'b1;
    mode <= m; sensor_index <= s;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    rot_0 <= a0; rot_1 <= a1; rot_2 <= a2; rot_3 <= a3;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pose(m, s, px, py, pz, a0, a1, a2, a3);
    items_sent++;
    mode_count[m]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    drain();
    scale_we <= 1'b1;
    scale_data <= v;
    @(posedge clk);
    scale_we <= 1'b0;
    scale_reg = v;
  endtask

  task automatic send_random(mode_t m);
    send_pose(m, 6'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_translation();
    send_pose(MODE_TRANS, 6'd0, 32'sh7fffffff, -32'sh80000000, 32'sd0, 0, 0, 0, 0);
    send_pose(MODE_TRANS, 6'd63, 32'sd1, -32'sd1, 32'sh00010000, 0, 0, 0, 0);
    write_scale(16'hffff);
    send_pose(MODE_TRANS, 6'd5, 32'sh7fffffff, -32'sh80000000, 32'sh00001000, 0, 0, 0, 0);
    send_pose(MODE_BOTH, 6'd9, 32'sh00012345, -32'sh00012345, 32'sd7,
              16'sd16384, 0, 0, 0);
    write_scale(16'd0);
    send_pose(MODE_TRANS, 6'd42, 32'sh7fffffff, -32'sh80000000, -32'sd1, 0, 0, 0, 0);
    write_scale(16'd10404);
    send_pose(MODE_TRANS, 6'd1, 32'sh00010000, -32'sh00028000, 32'sh01000000, 0, 0, 0, 0);
  endtask

  task automatic test_quaternion();
    send_pose(MODE_QUAT, 6'd3, 0, 0, 0, 16'sd16384, 0, 0, 0);
    send_pose(MODE_QUAT, 6'd4, 0, 0, 0, 16'sd11585, 16'sd11585, 0, 0);
    // non-unit quaternions saturate
    send_pose(MODE_QUAT, 6'd62, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pose(MODE_QUAT, 6'd61, 0, 0, 0, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_pose(MODE_BOTH, 6'd17, 32'sh7fffffff, 32'sd1, -32'sh80000000,
              -16'sh8000, 16'sh7fff, -16'sd1, 16'sd1);
  endtask

  task automatic test_euler();
    send_pose(MODE_EULER, 6'd0, 32'sd5, 32'sd6, 32'sd7, 0, 0, 0, 16'sh7fff);
    send_pose(MODE_EULER, 6'd11, 0, 0, 0, 16'sd5760, -16'sd5760, 16'sd11520, 16'sh1234);
    send_pose(MODE_EULER, 6'd12, 0, 0, 0, 16'sh7fff, -16'sh8000, 16'sd2880, -16'sd1);
    send_pose(MODE_EULER, 6'd13, 0, 0, 0, 16'sd2881, 16'sd2879, -16'sd17280, 0);
    send_pose(MODE_EULER, 6'd14, 32'sh7fffffff, 0, 0, 16'sd1, -16'sd1, 16'sd23040, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 100; i++) begin
      if (i % 10 == 0) burst = ($urandom_range(2) == 0);
      if (i % 25 == 24) write_scale(16'($urandom));
      send_random(mode_t'($urandom_range(3)));
    end
    burst = 1'b0;
  endtask

  always @(posedge clk) begin
    pose_result_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind %0d sensor %0d", kind, sensor_out);
      end else begin
        e = pending_results.pop_front();
        if (sensor_out !== e.sensor || kind !== e.kind || value_0 !== e.v0 ||
            value_1 !== e.v1 || value_2 !== e.v2 || last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected s%0d k%0d %0d %0d %0d l%0d, got s%0d k%0d %0d %0d %0d l%0d",
                     e.sensor, e.kind, e.v0, e.v1, e.v2, e.last,
                     sensor_out, kind, value_0, value_1, value_2, last);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_translation();
    test_quaternion();
    test_euler();
    write_scale(16'd4096);
    test_random();
    drain();
    $display("sent %0d items (modes 0..3: %0d %0d %0d %0d), checked %0d results",
             items_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pose_to_rotation_matrix test passed");
    end else begin
      $display("pose_to_rotation_matrix test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("pose_to_rotation_matrix test failed");
    $finish;
  end

endmodule

// ===== pose_to_rotation_matrix.f =====
rtl/ptrm_pkg.sv
rtl/ptrm_trig.sv
rtl/ptrm_euler.sv
rtl/ptrm_out.sv
rtl/pose_to_rotation_matrix.sv
test/pose_to_rotation_matrix_tb.sv
